// File: design/plstat_pkg.sv
package plstat_pkg;

  localparam int COUNT_BITS_DEF = 48;
  localparam int LEN_W          = 16;
  localparam int OUT_CNT_W      = 48;
  localparam int SUM_W          = 64;
  localparam int NUM_BINS       = 7;
  localparam int BIN_W          = 3;
  localparam int OUT_W          = OUT_CNT_W * (NUM_BINS + 2) + 2 * LEN_W + SUM_W;

  localparam logic [LEN_W-1:0] SNAP_RESET = '1;

  typedef logic [BIN_W-1:0] bin_t;

  localparam logic [LEN_W-1:0] BIN_LIMIT [NUM_BINS-1] = '{
    16'd64, 16'd128, 16'd256, 16'd512, 16'd1024, 16'd1518
  };

  typedef struct packed {
    logic rd_en;
    bin_t rd_bin;
  } bin_req_t;

  typedef struct packed {
    logic wr_en;
    bin_t bin;
  } bin_upd_t;

  function automatic bin_t bin_of(input logic [LEN_W-1:0] len);
    bin_t idx;
    idx = bin_t'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (len <= BIN_LIMIT[i]) begin
        idx = bin_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: design/packet_length_statistics_top.sv
// Packet length statistics with a per-size-class histogram.
// Input channel in_*: one transfer per packet or per heartbeat tick. in_tuser
// carries the mode (0 = packet, 1 = tick) and in_tdata the packet length.
// Output channel out_*: one transfer per input transfer, carrying the full
// statistics snapshot taken after that item's update.
// Configuration channel cfg_*: writes the snapshot length, which also loads
// the shortest length while no packet has been counted. It is ready whenever
// no item is in the update stage.
// An input transfer is registered in the update stage; its result is then
// registered in the output register, from which it is offered.
// Throughput: one item per cycle while the receiver takes results, set by the
// read-modify-write of the bin counter memory, whose back-to-back updates of
// one bin are forwarded around the memory read.
// Reset (synchronous, rst_n low): all counters zero, snapshot and shortest
// length 65535, longest length zero; the bin memory entries are marked
// empty by valid bits, so no clearing pass is needed.
// When the receiver stalls, the result stays in the output register, one
// further item waits in the update stage and in_tready then falls.
module packet_length_statistics_top #(
  parameter int COUNT_BITS = plstat_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [plstat_pkg::LEN_W-1:0]   cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // packet_length
  input  logic [plstat_pkg::LEN_W-1:0]   in_tdata,
  // mode
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // total_packets, bin_upto_64, bin_upto_128, bin_upto_256, bin_upto_512,
  // bin_upto_1024, bin_upto_1518, bin_above_1518, shortest_length,
  // longest_length, byte_total, period_packets
  output logic [plstat_pkg::OUT_W-1:0]   out_tdata
);

  localparam int CW = plstat_pkg::OUT_CNT_W;
  localparam int LW = plstat_pkg::LEN_W;
  localparam int SW = plstat_pkg::SUM_W;
  localparam int NB = plstat_pkg::NUM_BINS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                     in_fire, cfg_fire, s1_adv, s1_pkt, s1_tick;
  logic                     s1_valid_r, s1_tick_r;
  logic [LW-1:0]            s1_len_r;
  plstat_pkg::bin_t         s1_bin_r;
  logic                     out_valid_r;
  logic [plstat_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic [COUNT_BITS-1:0]    pkt_total_r, pkt_total_nxt;
  logic [COUNT_BITS-1:0]    last_tick_r, last_tick_nxt;
  logic [COUNT_BITS-1:0]    period;
  logic [LW-1:0]            snap_r, min_r, min_nxt, max_r, max_nxt;
  logic [SW-1:0]            sum_r, sum_nxt;
  logic [SW:0]              sum_ext;
  logic [COUNT_BITS-1:0]    bins_r [NB];
  logic [COUNT_BITS-1:0]    bin_val [NB];
  logic [COUNT_BITS-1:0]    new_count;

  plstat_pkg::bin_req_t     mem_req;
  plstat_pkg::bin_upd_t     mem_upd;

  assign in_fire    = in_tvalid && in_tready;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign cfg_ready  = !s1_valid_r;
  assign s1_pkt     = s1_valid_r && !s1_tick_r;
  assign s1_tick    = s1_valid_r && s1_tick_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign mem_req.rd_en  = in_fire && !in_tuser[0];
  assign mem_req.rd_bin = plstat_pkg::bin_of(in_tdata);
  assign mem_upd.wr_en  = s1_adv && !s1_tick_r;
  assign mem_upd.bin    = s1_bin_r;

  plstat_bin_mem #(
    .COUNT_BITS (COUNT_BITS)
  ) u_bin_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mem_req),
    .upd       (mem_upd),
    .new_count (new_count)
  );

  always_comb begin
    pkt_total_nxt = pkt_total_r;
    last_tick_nxt = last_tick_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    period        = '0;
    sum_ext       = {1'b0, sum_r} + (SW + 1)'(s1_len_r);
    if (s1_pkt) begin
      pkt_total_nxt = (pkt_total_r == CNT_MAX) ? pkt_total_r
                                               : pkt_total_r + COUNT_BITS'(1);
      if (s1_len_r < min_r) begin
        min_nxt = s1_len_r;
      end
      if (s1_len_r > max_r) begin
        max_nxt = s1_len_r;
      end
      sum_nxt = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
    end else if (s1_tick) begin
      period        = pkt_total_r - last_tick_r;
      last_tick_nxt = pkt_total_r;
    end
    for (int i = 0; i < NB; i++) begin
      bin_val[i] = (s1_pkt && (s1_bin_r == plstat_pkg::bin_t'(i))) ? new_count : bins_r[i];
    end
    out_data_nxt = '0;
    out_data_nxt[CW-1:0] = CW'(pkt_total_nxt);
    for (int i = 0; i < NB; i++) begin
      out_data_nxt[CW*(i+1) +: CW] = CW'(bin_val[i]);
    end
    out_data_nxt[CW*(NB+1) +: LW]          = min_nxt;
    out_data_nxt[CW*(NB+1) + LW +: LW]     = max_nxt;
    out_data_nxt[CW*(NB+1) + 2*LW +: SW]   = sum_nxt;
    out_data_nxt[CW*(NB+1) + 2*LW + SW +: CW] = CW'(period);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r <= in_tuser[0];
      s1_len_r  <= in_tdata;
      s1_bin_r  <= plstat_pkg::bin_of(in_tdata);
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pkt_total_r <= '0;
      last_tick_r <= '0;
      snap_r      <= plstat_pkg::SNAP_RESET;
      min_r       <= plstat_pkg::SNAP_RESET;
      max_r       <= '0;
      sum_r       <= '0;
      for (int i = 0; i < NB; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        snap_r <= cfg_data;
        if (pkt_total_r == '0) begin
          min_r <= cfg_data;
        end
      end
      if (s1_adv) begin
        pkt_total_r <= pkt_total_nxt;
        last_tick_r <= last_tick_nxt;
        min_r       <= min_nxt;
        max_r       <= max_nxt;
        sum_r       <= sum_nxt;
        for (int i = 0; i < NB; i++) begin
          bins_r[i] <= bin_val[i];
        end
      end
    end
  end

  a_accept_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("Accepted transfer did not enter the update stage.");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (pkt_total_r >= $past(pkt_total_r)))
    else $error("Packet total decreased.");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (pkt_total_r != '0) |-> (min_r <= max_r))
    else $error("Shortest length exceeds longest length after a packet.");

endmodule

// File: design/plstat_bin_mem.sv
module plstat_bin_mem #(
  parameter int COUNT_BITS = plstat_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  plstat_pkg::bin_req_t   req,
  input  plstat_pkg::bin_upd_t   upd,
  output logic [COUNT_BITS-1:0]  new_count
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0]           mem [plstat_pkg::NUM_BINS];
  logic [plstat_pkg::NUM_BINS-1:0] valid_r;
  logic [COUNT_BITS-1:0]           rd_data_r;
  logic                            rd_vld_r;
  logic                            fwd_hit_r;
  logic [COUNT_BITS-1:0]           fwd_data_r;
  logic [COUNT_BITS-1:0]           cur_count;

  // The previous update lands in the memory on the same edge as this read,
  // so its result is taken from the forwarding register instead.
  always_comb begin
    if (fwd_hit_r) begin
      cur_count = fwd_data_r;
    end else if (rd_vld_r) begin
      cur_count = rd_data_r;
    end else begin
      cur_count = '0;
    end
    new_count = (cur_count == CNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (upd.wr_en) begin
      mem[upd.bin] <= new_count;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_bin];
      fwd_data_r <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (upd.wr_en) begin
        valid_r[upd.bin] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r  <= valid_r[req.rd_bin];
        fwd_hit_r <= upd.wr_en && (upd.bin == req.rd_bin);
      end
    end
  end

  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    upd.wr_en |=> valid_r[$past(upd.bin)])
    else $error("Bin entry not marked valid after an update.");

  a_fwd_same_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (req.rd_en && upd.wr_en && (upd.bin == req.rd_bin)) |=> fwd_hit_r)
    else $error("Back-to-back update of one bin was not forwarded.");

endmodule

// File: verif/packet_length_statistics_top_tb.sv
`timescale 1ns / 100ps

module packet_length_statistics_top_tb;

  localparam int LEN_W       = plstat_pkg::LEN_W;
  localparam int OUT_CNT_W   = plstat_pkg::OUT_CNT_W;
  localparam int SUM_W       = plstat_pkg::SUM_W;
  localparam int NUM_BINS    = plstat_pkg::NUM_BINS;
  localparam int OUT_W       = plstat_pkg::OUT_W;
  localparam logic [LEN_W-1:0] SNAP_RESET = plstat_pkg::SNAP_RESET;
  localparam int CNT_W       = plstat_pkg::COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 300;
  localparam int CLASS_BOUND [6] = '{64, 128, 256, 512, 1024, 1518};
  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - CNT_W);
  localparam logic [63:0] SUM_MAX = {64{1'b1}};

  typedef enum logic {
    MODE_PACKET = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

  typedef enum int {
    CLS_UPTO_64, CLS_UPTO_128, CLS_UPTO_256, CLS_UPTO_512, CLS_UPTO_1024, CLS_UPTO_1518,
    CLS_ABOVE_1518
  } size_class_e;

  typedef struct packed {
    logic [OUT_CNT_W-1:0]                period_packets;
    logic [SUM_W-1:0]                    byte_total;
    logic [LEN_W-1:0]                    longest_length;
    logic [LEN_W-1:0]                    shortest_length;
    logic [NUM_BINS-1:0][OUT_CNT_W-1:0]  size_counts;
    logic [OUT_CNT_W-1:0]                total_packets;
  } snapshot_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [LEN_W-1:0]   in_tdata;
  logic [0:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;

  logic [LEN_W-1:0]   snap_model;
  logic [63:0]        total_model;
  logic [63:0]        class_model [NUM_BINS];
  logic [LEN_W-1:0]   shortest_model;
  logic [LEN_W-1:0]   longest_model;
  logic [63:0]        sum_model;
  logic [63:0]        last_tick_model;

  snapshot_t          expected_snapshots [$];
  snapshot_t          got_snap;
  snapshot_t          want_snap;

  int                 mismatch_count;
  int                 results_checked;
  int                 packets_sent;
  int                 ticks_sent;
  int                 snap_writes;
  int                 cycle_count;
  bit                 offering;
  bit                 sender_steady;
  int                 hold_request;
  int                 hold_seen;
  int                 hold_left;
  int                 stall_left;
  int                 regime_left;
  bit                 receiver_steady;

  packet_length_statistics_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               expected_snapshots.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mode_e random_mode();
    return ($urandom_range(0, 9) == 0) ? MODE_TICK : MODE_PACKET;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int pick;
    int bound;
    pick  = $urandom_range(0, 99);
    bound = CLASS_BOUND[$urandom_range(0, 5)];
    if (pick < 40) return LEN_W'(bound + $urandom_range(0, 2) - 1);
    if (pick < 75) return LEN_W'($urandom_range(0, 2000));
    if (pick < 90) return LEN_W'($urandom_range(0, 65535));
    return LEN_W'($urandom_range(0, 80));
  endfunction

  function automatic size_class_e size_class_of(input logic [LEN_W-1:0] len);
    for (int i = 0; i < 6; i++) begin
      if (int'(len) <= CLASS_BOUND[i]) return size_class_e'(i);
    end
    return CLS_ABOVE_1518;
  endfunction

  function automatic logic [63:0] count_up(input logic [63:0] value);
    return (value >= CNT_MAX) ? CNT_MAX : value + 64'd1;
  endfunction

  task automatic clear_statistics_model();
    snap_model      = SNAP_RESET;
    total_model     = '0;
    for (int i = 0; i < NUM_BINS; i++) class_model[i] = '0;
    shortest_model  = SNAP_RESET;
    longest_model   = '0;
    sum_model       = '0;
    last_tick_model = '0;
  endtask

  task automatic update_statistics_model(input mode_e mode, input logic [LEN_W-1:0] len);
    snapshot_t   snap;
    logic [63:0] period;
    size_class_e cls;
    period = '0;
    if (mode == MODE_PACKET) begin
      cls = size_class_of(len);
      total_model = count_up(total_model);
      class_model[cls] = count_up(class_model[cls]);
      if (len < shortest_model) shortest_model = len;
      if (len > longest_model) longest_model = len;
      sum_model = (sum_model > SUM_MAX - 64'(len)) ? SUM_MAX : sum_model + 64'(len);
      packets_sent++;
    end else begin
      period = total_model - last_tick_model;
      last_tick_model = total_model;
      ticks_sent++;
    end
    snap.total_packets = total_model[OUT_CNT_W-1:0];
    for (int i = 0; i < NUM_BINS; i++) snap.size_counts[i] = class_model[i][OUT_CNT_W-1:0];
    snap.shortest_length = shortest_model;
    snap.longest_length  = longest_model;
    snap.byte_total      = sum_model;
    snap.period_packets  = period[OUT_CNT_W-1:0];
    expected_snapshots.push_back(snap);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 20) begin
      $display("Mismatch on %s at result %0d: got %0d, expected %0d.", what, results_checked,
               got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_snapshots.size() == 0) begin
        report_mismatch("a result with none outstanding", 64'd0, 64'd0);
      end else begin
        want_snap = expected_snapshots.pop_front();
        got_snap  = out_tdata;
        if (got_snap.total_packets != want_snap.total_packets)
          report_mismatch("total_packets", got_snap.total_packets, want_snap.total_packets);
        for (int i = 0; i < NUM_BINS; i++) begin
          if (got_snap.size_counts[i] != want_snap.size_counts[i])
            report_mismatch($sformatf("size class %0d", i), got_snap.size_counts[i],
                            want_snap.size_counts[i]);
        end
        if (got_snap.shortest_length != want_snap.shortest_length)
          report_mismatch("shortest_length", got_snap.shortest_length,
                          want_snap.shortest_length);
        if (got_snap.longest_length != want_snap.longest_length)
          report_mismatch("longest_length", got_snap.longest_length, want_snap.longest_length);
        if (got_snap.byte_total != want_snap.byte_total)
          report_mismatch("byte_total", got_snap.byte_total, want_snap.byte_total);
        if (got_snap.period_packets != want_snap.period_packets)
          report_mismatch("period_packets", got_snap.period_packets, want_snap.period_packets);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = LONG_HOLD;
    end
    if (regime_left == 0) begin
      regime_left     = $urandom_range(50, 200);
      receiver_steady = ($urandom_range(0, 3) == 0);
    end
    regime_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!receiver_steady && $urandom_range(0, 2) == 0) begin
      stall_left = pick_gap();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input mode_e mode, input logic [LEN_W-1:0] len);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      if (offering) in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= len;
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    update_statistics_model(mode, len);
  endtask

  task automatic wait_for_results();
    if (offering) in_tvalid <= 1'b0;
    offering = 1'b0;
    while (expected_snapshots.size() != 0) @(posedge clk);
  endtask

  task automatic write_snap_length(input logic [LEN_W-1:0] value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    snap_model = value;
    if (total_model == 0) shortest_model = value;
    snap_writes++;
    @(posedge clk);
  endtask

  task automatic test_snapshot_before_traffic();
    send_item(MODE_TICK, 16'h0000);
    write_snap_length(16'h0000);
    send_item(MODE_TICK, 16'hFFFF);
    write_snap_length(16'hFFFF);
    send_item(MODE_TICK, 16'h1234);
    write_snap_length(16'd300);
    send_item(MODE_TICK, 16'h0000);
  endtask

  task automatic test_size_class_edges();
    logic [LEN_W-1:0] lengths [15];
    lengths = '{16'd400, 16'd64, 16'd65, 16'd128, 16'd129, 16'd256, 16'd257, 16'd512,
                16'd513, 16'd1024, 16'd1025, 16'd1518, 16'd1519, 16'hFFFF, 16'd0};
    foreach (lengths[i]) send_item(MODE_PACKET, lengths[i]);
    send_item(MODE_TICK, 16'hFFFF);
    send_item(MODE_TICK, 16'h0000);
    send_item(MODE_PACKET, 16'd1);
    send_item(MODE_TICK, 16'h5A5A);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    logic [LEN_W-1:0] settings [6];
    settings = '{16'hFFFF, 16'h0000, LEN_W'($urandom), 16'd1518, LEN_W'($urandom), 16'd64};
    foreach (settings[p]) begin
      write_snap_length(settings[p]);
      for (int n = 0; n < 180; n++) begin
        if (n % 30 == 0) sender_steady = ($urandom_range(0, 3) == 0);
        send_item(random_mode(), random_length());
      end
      sender_steady = 1'b0;
    end
    wait_for_results();
  endtask

  task automatic test_result_backpressure();
    wait_for_results();
    hold_request <= hold_request + 1;
    sender_steady = 1'b1;
    repeat (40) send_item(random_mode(), random_length());
    sender_steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    clear_statistics_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_snapshot_before_traffic();
    test_size_class_edges();
    test_result_backpressure();
    test_random_traffic();
    test_result_backpressure();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d packets and %0d ticks across %0d snapshot-length writes,",
             packets_sent, ticks_sent, snap_writes);
    $display("with long output hold-offs; %0d snapshots checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_snapshots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
